@@ rtl/tvs_pkg.sv @@
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants for the tensor value statistics block.
// ----------------------------------------------------------------------------
package tvs_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] FMT_FP32 = 2'd0;
   localparam logic [1:0] FMT_FP16 = 2'd1;

   localparam logic [1:0] CSR_INPUT_FORMAT   = 2'd0;
   localparam logic [1:0] CSR_SPARSE_EPSILON = 2'd1;
   localparam logic [1:0] CSR_ELEMENT_LIMIT  = 2'd2;

   localparam logic [1:0]  INPUT_FORMAT_RESET   = FMT_FP32;
   localparam logic [31:0] SPARSE_EPSILON_RESET = 32'h358637BD;
   localparam logic [31:0] ELEMENT_LIMIT_RESET  = 32'hFFFFFFFF;

   localparam logic [31:0] FP32_INF_MAG = 32'h7F800000;

   typedef struct packed {
      logic [1:0]  input_format;
      logic [31:0] sparse_epsilon;
      logic [31:0] element_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0] bits;
      logic        counted;
      logic        is_nan;
      logic        is_inf;
      logic        sparse;
      logic        last;
      logic        unsupported;
   } entry_type;

endpackage

@@ rtl/tvs_if.sv @@
// ----------------------------------------------------------------------------
// tvs_if
// Request and response channels of the tensor value statistics block.
// ----------------------------------------------------------------------------
interface tvs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_bits;
   logic        last_element;

   modport source (output valid, output sample_bits, output last_element, input ready);
   modport sink (input valid, input sample_bits, input last_element, output ready);
endinterface

interface tvs_rsp_if;
   logic        valid;
   logic        ready;
   logic        saw_nan;
   logic        saw_inf;
   logic [31:0] mean_bits;
   logic [31:0] sparsity_bits;
   logic [31:0] max_abs_bits;

   modport source (output valid, output saw_nan, output saw_inf, output mean_bits,
                   output sparsity_bits, output max_abs_bits, input ready);
   modport sink (input valid, input saw_nan, input saw_inf, input mean_bits,
                 input sparsity_bits, input max_abs_bits, output ready);
endinterface

@@ rtl/tvs_front.sv @@
// ----------------------------------------------------------------------------
// tvs_front
// Accepts requests, widens fp16 to fp32, applies the element limit and
// classifies each element before it is queued.
// ----------------------------------------------------------------------------
module tvs_front
   import tvs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   tvs_req_if.sink   req_channel,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_entry
);

   localparam int LW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [9:0] m;
      logic [9:0] ms;
      logic [3:0] pos;
      logic [7:0] ex;
      m = h[9:0];
      pos = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            pos = 4'(i);
         end
      end
      ms = m << (4'd10 - pos);
      ex = 8'd103 + {4'd0, pos};
      if (h[14:10] == 5'h1F) begin
         return {h[15], 8'hFF, m, 13'd0};
      end else if (h[14:10] == 5'd0) begin
         if (m == 10'd0) begin
            return {h[15], 31'd0};
         end
         return {h[15], ex, ms, 13'd0};
      end
      return {h[15], {3'd0, h[14:10]} + 8'd112, m, 13'd0};
   endfunction

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [LW-1:0]          count_wide, limit_wide;
   logic                   supported, counted, accept;
   logic [31:0]            bits, mag;

   assign count_wide = LW'(count_ff);
   assign limit_wide = LW'(cfg.element_limit);
   assign supported  = (cfg.input_format == FMT_FP32) || (cfg.input_format == FMT_FP16);
   assign counted    = supported && (count_wide < limit_wide) && (count_ff != '1);
   assign bits       = (cfg.input_format == FMT_FP16) ?
                       half_to_single(req_channel.sample_bits[15:0]) : req_channel.sample_bits;
   assign mag        = {1'b0, bits[30:0]};

   assign req_channel.ready = push_ready;
   assign accept            = req_channel.valid && req_channel.ready;
   assign push_valid        = req_channel.valid && (counted || req_channel.last_element);

   always_comb begin
      push_entry.bits        = bits;
      push_entry.counted     = counted;
      push_entry.is_nan      = mag > FP32_INF_MAG;
      push_entry.is_inf      = mag == FP32_INF_MAG;
      push_entry.sparse      = (cfg.sparse_epsilon <= FP32_INF_MAG) && (mag < cfg.sparse_epsilon);
      push_entry.last        = req_channel.last_element;
      push_entry.unsupported = !supported;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_channel.last_element) begin
            count_in = '0;
         end else if (counted) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/tvs_queue.sv @@
// ----------------------------------------------------------------------------
// tvs_queue
// Small first-in first-out queue of classified elements between the front
// and the back.
// ----------------------------------------------------------------------------
module tvs_queue
   import tvs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNTW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = slots_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= in_entry;
      end
   end

endmodule

@@ rtl/tvs_div.sv @@
// ----------------------------------------------------------------------------
// tvs_div
// Sequential unit that turns the counts into fp32 and forms
// mean = sum / n and sparsity = sparse / n, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tvs_div
   import tvs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            sum_bits,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [COUNT_WIDTH-1:0] tally,
   output logic                   done,
   output logic [31:0]            mean_bits,
   output logic [31:0]            sparsity_bits
);

   localparam int CXW = COUNT_WIDTH + 24;
   localparam int PW  = $clog2(COUNT_WIDTH);

   localparam logic [2:0] D_IDLE  = 3'd0;
   localparam logic [2:0] D_CONV  = 3'd1;
   localparam logic [2:0] D_SETUP = 3'd2;
   localparam logic [2:0] D_NORM  = 3'd3;
   localparam logic [2:0] D_ITER  = 3'd4;
   localparam logic [2:0] D_ROUND = 3'd5;

   localparam logic [1:0] P_COUNT  = 2'd0;
   localparam logic [1:0] P_TALLY  = 2'd1;
   localparam logic [1:0] P_MEAN   = 2'd2;
   localparam logic [1:0] P_SPARSE = 2'd3;

   logic [2:0]             state_ff;
   logic [1:0]             phase_ff;
   logic                   done_ff;
   logic [CXW-1:0]         cx_ff;
   logic [PW-1:0]          cp_ff;
   logic [31:0]            sum_ff, nf_ff, tf_ff, mean_ff, spars_ff;
   logic [COUNT_WIDTH-1:0] tally_ff;
   logic                   sign_ff;
   logic [23:0]            ma_ff, mb_ff;
   logic [25:0]            rem_ff, q_ff;
   logic signed [9:0]      qe_ff;
   logic [4:0]             it_ff;

   logic                   res_store;
   logic [31:0]            res_val;
   logic [31:0]            conv_val, round_val, setup_a;
   logic                   setup_special;
   logic [31:0]            setup_val;
   logic                   conv_inc, round_inc, round_sticky, lost;
   logic [7:0]             round_field;
   logic [25:0]            qs;
   logic [4:0]             sc;
   logic signed [9:0]      sv;
   logic [24:0]            diff;
   logic                   ge;

   always_comb begin
      conv_inc = cx_ff[CXW-25] && ((|cx_ff[CXW-26:0]) || cx_ff[CXW-24]);
      conv_val = {1'b0, {8'(cp_ff) + 8'd127, cx_ff[CXW-2 -: 23]} + 31'(conv_inc)};
   end

   always_comb begin
      setup_a       = (phase_ff == P_MEAN) ? sum_ff : tf_ff;
      setup_special = (setup_a[30:23] == 8'hFF) || (setup_a[30:0] == 31'd0);
      setup_val     = setup_a;
   end

   always_comb begin
      ge   = rem_ff >= {2'b00, mb_ff};
      diff = ge ? 25'(rem_ff - {2'b00, mb_ff}) : rem_ff[24:0];
   end

   always_comb begin
      round_sticky = rem_ff != 26'd0;
      sv           = 10'sd1 - qe_ff;
      sc           = (sv > 10'sd27) ? 5'd27 : sv[4:0];
      qs           = q_ff;
      lost         = 1'b0;
      round_field  = qe_ff[7:0];
      if (qe_ff <= 10'sd0) begin
         qs          = q_ff >> sc;
         lost        = (qs << sc) != q_ff;
         round_field = 8'd0;
      end
      round_inc = qs[1] && (qs[0] || round_sticky || lost || qs[2]);
      if (qe_ff >= 10'sd255) begin
         round_val = {sign_ff, 8'hFF, 23'd0};
      end else begin
         round_val = {sign_ff, {round_field, qs[24:2]} + 31'(round_inc)};
      end
   end

   always_comb begin
      res_store = 1'b0;
      res_val   = 32'd0;
      unique case (state_ff)
         D_CONV: begin
            if (cx_ff == '0) begin
               res_store = 1'b1;
            end else if (cx_ff[CXW-1]) begin
               res_store = 1'b1;
               res_val   = conv_val;
            end
         end
         D_SETUP: begin
            res_store = setup_special;
            res_val   = setup_val;
         end
         D_ROUND: begin
            res_store = 1'b1;
            res_val   = round_val;
         end
         D_IDLE, D_NORM, D_ITER: begin
            res_store = 1'b0;
         end
         default: begin
            res_store = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         phase_ff <= P_COUNT;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  state_ff <= D_CONV;
                  phase_ff <= P_COUNT;
               end
            end
            D_NORM: begin
               if (ma_ff[23]) begin
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               if (it_ff == 5'd25) begin
                  state_ff <= D_ROUND;
               end
            end
            D_CONV, D_SETUP, D_ROUND: begin
               if (res_store) begin
                  unique case (phase_ff)
                     P_COUNT: begin
                        phase_ff <= P_TALLY;
                     end
                     P_TALLY: begin
                        phase_ff <= P_MEAN;
                        state_ff <= D_SETUP;
                     end
                     P_MEAN: begin
                        phase_ff <= P_SPARSE;
                        state_ff <= D_SETUP;
                     end
                     P_SPARSE: begin
                        state_ff <= D_IDLE;
                        done_ff  <= 1'b1;
                     end
                     default: begin
                        state_ff <= D_IDLE;
                     end
                  endcase
               end else if (state_ff == D_SETUP) begin
                  state_ff <= D_NORM;
               end
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               sum_ff   <= sum_bits;
               tally_ff <= tally;
               cx_ff    <= {count, 24'd0};
               cp_ff    <= PW'(COUNT_WIDTH - 1);
            end
         end
         D_CONV: begin
            if (res_store) begin
               if (phase_ff == P_COUNT) begin
                  nf_ff <= res_val;
                  cx_ff <= {tally_ff, 24'd0};
                  cp_ff <= PW'(COUNT_WIDTH - 1);
               end else begin
                  tf_ff <= res_val;
               end
            end else begin
               cx_ff <= cx_ff << 1;
               cp_ff <= cp_ff - PW'(1);
            end
         end
         D_SETUP: begin
            if (res_store) begin
               if (phase_ff == P_MEAN) begin
                  mean_ff <= res_val;
               end else begin
                  spars_ff <= res_val;
               end
            end
            sign_ff <= setup_a[31];
            ma_ff   <= {setup_a[30:23] != 8'd0, setup_a[22:0]};
            mb_ff   <= {1'b1, nf_ff[22:0]};
            qe_ff   <= $signed({2'b00, (setup_a[30:23] == 8'd0) ? 8'd1 : setup_a[30:23]})
                       - $signed({2'b00, nf_ff[30:23]}) + 10'sd127;
         end
         D_NORM: begin
            if (ma_ff[23]) begin
               if (ma_ff < mb_ff) begin
                  rem_ff <= {1'b0, ma_ff, 1'b0};
                  qe_ff  <= qe_ff - 10'sd1;
               end else begin
                  rem_ff <= {2'b00, ma_ff};
               end
               it_ff <= 5'd0;
            end else begin
               ma_ff <= ma_ff << 1;
               qe_ff <= qe_ff - 10'sd1;
            end
         end
         D_ITER: begin
            rem_ff <= {diff, 1'b0};
            q_ff   <= {q_ff[24:0], ge};
            it_ff  <= it_ff + 5'd1;
         end
         D_ROUND: begin
            if (phase_ff == P_MEAN) begin
               mean_ff <= res_val;
            end else begin
               spars_ff <= res_val;
            end
         end
         default: begin
         end
      endcase
   end

   assign done          = done_ff;
   assign mean_bits     = mean_ff;
   assign sparsity_bits = spars_ff;

endmodule

@@ rtl/tvs_back.sv @@
// ----------------------------------------------------------------------------
// tvs_back
// Carries out queued elements: running fp32 sum, largest magnitude, counts
// and flags, and builds the response on the last element.
// ----------------------------------------------------------------------------
module tvs_back
   import tvs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_entry,
   tvs_rsp_if.source rsp_channel
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NORM = 3'd1;
   localparam logic [2:0] S_FIN  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]             state_ff;
   logic [31:0]            sum_ff, max_ff;
   logic [COUNT_WIDTH-1:0] n_ff, tally_ff;
   logic                   nan_ff, inf_ff, last_ff, unsup_ff;

   logic                   a_sign_ff, a_sub_ff, a_keep_ff;
   logic [7:0]             a_exp_ff;
   logic [27:0]            a_mant_ff;

   logic                   r_nan_ff, r_inf_ff;
   logic [31:0]            r_mean_ff, r_spars_ff, r_max_ff;

   logic                   pop, do_add, x_big, sub, div_start, div_done;
   logic [31:0]            big, sml, mag, add_res;
   logic [7:0]             eb, es, d;
   logic [23:0]            mb, ms;
   logic [4:0]             dc;
   logic [26:0]            ms_ext, shifted, aligned;
   logic [27:0]            mant28;
   logic                   lost_bits;
   logic [31:0]            div_mean, div_spars;

   logic [26:0]            m27;
   logic [8:0]             exp9;
   logic [4:0]             lz, sh;
   logic [7:0]             lim, field;
   logic                   inc;

   assign pop_ready = state_ff == S_IDLE;
   assign pop       = pop_valid && pop_ready;
   assign do_add    = pop_entry.counted && !pop_entry.is_nan && !pop_entry.is_inf;
   assign mag       = {1'b0, pop_entry.bits[30:0]};

   always_comb begin
      x_big     = sum_ff[30:0] >= pop_entry.bits[30:0];
      big       = x_big ? sum_ff : pop_entry.bits;
      sml       = x_big ? pop_entry.bits : sum_ff;
      eb        = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es        = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      mb        = {big[30:23] != 8'd0, big[22:0]};
      ms        = {sml[30:23] != 8'd0, sml[22:0]};
      d         = eb - es;
      dc        = (d > 8'd27) ? 5'd27 : d[4:0];
      ms_ext    = {ms, 3'd0};
      shifted   = ms_ext >> dc;
      lost_bits = (shifted << dc) != ms_ext;
      aligned   = {shifted[26:1], shifted[0] | lost_bits};
      sub       = big[31] ^ sml[31];
      mant28    = sub ? ({1'b0, mb, 3'd0} - {1'b0, aligned})
                      : ({1'b0, mb, 3'd0} + {1'b0, aligned});
   end

   always_comb begin
      lz = 5'd26;
      for (int i = 0; i < 27; i++) begin
         if (a_mant_ff[i]) begin
            lz = 5'(26 - i);
         end
      end
      lim = a_exp_ff - 8'd1;
      sh  = ({3'd0, lz} < lim) ? lz : lim[4:0];
      if (a_mant_ff[27]) begin
         m27  = {a_mant_ff[27:2], a_mant_ff[1] | a_mant_ff[0]};
         exp9 = {1'b0, a_exp_ff} + 9'd1;
      end else begin
         m27  = a_mant_ff[26:0] << sh;
         exp9 = {1'b0, a_exp_ff} - {4'd0, sh};
      end
      field = m27[26] ? exp9[7:0] : 8'd0;
      inc   = m27[2] && (m27[1] || m27[0] || m27[3]);
      if (a_keep_ff) begin
         add_res = sum_ff;
      end else if (a_mant_ff == 28'd0) begin
         add_res = a_sub_ff ? 32'd0 : {a_sign_ff, 31'd0};
      end else if (exp9 >= 9'd255) begin
         add_res = {a_sign_ff, 8'hFF, 23'd0};
      end else begin
         add_res = {a_sign_ff, {field, m27[25:3]} + 31'(inc)};
      end
   end

   assign div_start = (state_ff == S_FIN) && !unsup_ff && (n_ff != '0);

   tvs_div #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_div (
      .clock         (clock),
      .reset         (reset),
      .start         (div_start),
      .sum_bits      (sum_ff),
      .count         (n_ff),
      .tally         (tally_ff),
      .done          (div_done),
      .mean_bits     (div_mean),
      .sparsity_bits (div_spars)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sum_ff   <= 32'd0;
         max_ff   <= 32'd0;
         n_ff     <= '0;
         tally_ff <= '0;
         nan_ff   <= 1'b0;
         inf_ff   <= 1'b0;
         last_ff  <= 1'b0;
         unsup_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  if (pop_entry.counted) begin
                     n_ff   <= n_ff + COUNT_WIDTH'(1);
                     nan_ff <= nan_ff | pop_entry.is_nan;
                     inf_ff <= inf_ff | pop_entry.is_inf;
                  end
                  if (do_add && pop_entry.sparse) begin
                     tally_ff <= tally_ff + COUNT_WIDTH'(1);
                  end
                  if (do_add && (mag > max_ff)) begin
                     max_ff <= mag;
                  end
                  last_ff  <= pop_entry.last;
                  unsup_ff <= pop_entry.unsupported;
                  if (do_add) begin
                     state_ff <= S_NORM;
                  end else if (pop_entry.last) begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_NORM: begin
               sum_ff   <= add_res;
               state_ff <= last_ff ? S_FIN : S_IDLE;
            end
            S_FIN: begin
               state_ff <= div_start ? S_DIV : S_OUT;
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_channel.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if ((state_ff == S_FIN && !div_start) || (state_ff == S_DIV && div_done)) begin
            sum_ff   <= 32'd0;
            max_ff   <= 32'd0;
            n_ff     <= '0;
            tally_ff <= '0;
            nan_ff   <= 1'b0;
            inf_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && do_add) begin
         a_sign_ff <= big[31];
         a_exp_ff  <= eb;
         a_mant_ff <= mant28;
         a_sub_ff  <= sub;
         a_keep_ff <= sum_ff[30:23] == 8'hFF;
      end
      if (state_ff == S_FIN) begin
         r_nan_ff   <= nan_ff && !unsup_ff;
         r_inf_ff   <= inf_ff && !unsup_ff;
         r_max_ff   <= unsup_ff ? 32'd0 : max_ff;
         r_mean_ff  <= 32'd0;
         r_spars_ff <= 32'd0;
      end
      if (state_ff == S_DIV && div_done) begin
         r_mean_ff  <= div_mean;
         r_spars_ff <= div_spars;
      end
   end

   assign rsp_channel.valid         = state_ff == S_OUT;
   assign rsp_channel.saw_nan       = r_nan_ff;
   assign rsp_channel.saw_inf       = r_inf_ff;
   assign rsp_channel.mean_bits     = r_mean_ff;
   assign rsp_channel.sparsity_bits = r_spars_ff;
   assign rsp_channel.max_abs_bits  = r_max_ff;

   a_tally_within_count: assert property (@(posedge clock) disable iff (reset)
      tally_ff <= n_ff)
      else $error("sparse tally exceeds element count");

   a_add_then_round: assert property (@(posedge clock) disable iff (reset)
      (pop && do_add) |=> (state_ff == S_NORM))
      else $error("addition not followed by rounding step");

   a_div_to_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_done) |=> (state_ff == S_OUT && sum_ff == 32'd0))
      else $error("division result not presented or state not cleared");

endmodule

@@ rtl/tensor_value_statistics_top.sv @@
// ----------------------------------------------------------------------------
// tensor_value_statistics_top
// Running statistics (flags, mean, sparsity, largest magnitude) over a
// stream of fp32 or fp16 tensor elements.
// ----------------------------------------------------------------------------
// A finite element passes an align-and-add step into the running sum and a
// normalize-and-round step, and the next element needs that rounded sum.
// NaN and infinity skip the rounding step; elements past the limit are
// dropped at the front and never reach the back end unless they are last.
// A four-entry queue lets requests keep flowing while the back end works.
// On the last element the sequential divider converts both counts (one bit
// shift per cycle) and runs up to two 26-step divisions, with extra
// normalization shifts when the running sum is subnormal; the response then
// waits in an output register.
// ----------------------------------------------------------------------------
module tensor_value_statistics_top
   import tvs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tvs_req_if.sink     req_channel,
   tvs_rsp_if.source   rsp_channel,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INPUT_FORMAT:   cfg_in.input_format   = csr_write_data[1:0];
            CSR_SPARSE_EPSILON: cfg_in.sparse_epsilon = csr_write_data;
            CSR_ELEMENT_LIMIT:  cfg_in.element_limit  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_format   <= INPUT_FORMAT_RESET;
         cfg_ff.sparse_epsilon <= SPARSE_EPSILON_RESET;
         cfg_ff.element_limit  <= ELEMENT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tvs_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_channel (req_channel),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   tvs_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   tvs_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_channel (rsp_channel)
   );

endmodule
